/* rtl/latency_histogram_percentiles_core_macros.svh */
// assertion macros for the latency histogram core
`ifndef LATENCY_HISTOGRAM_PERCENTILES_CORE_MACROS_SVH
`define LATENCY_HISTOGRAM_PERCENTILES_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LHP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: label failed");
`define LHP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: label failed");
`else
`define LHP_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LHP_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/lhp_pkg.sv */
// shared types, constants and bucket functions of the latency histogram
`default_nettype none
package lhp_pkg;
  localparam int Buckets = 608;
  localparam int IdxW = 10;
  localparam int CntW = 32;

  typedef enum logic [1:0] {
    ACT_RECORD = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  localparam logic [1:0] CFG_PCT0 = 2'd0;

  function automatic logic [IdxW-1:0] slot_of(input logic [31:0] ns);
    logic [31:0] idx;
    begin
      if (ns >= 32'd560384)    idx = 32'd544 + ((ns - 32'd560384) >> 15);
      else if (ns >= 32'd70144) idx = 32'd424 + ((ns - 32'd70144) >> 12);
      else if (ns >= 32'd8704)  idx = 32'd304 + ((ns - 32'd8704) >> 9);
      else if (ns >= 32'd1024)  idx = 32'd184 + ((ns - 32'd1024) >> 6);
      else if (ns >= 32'd64)    idx = 32'd64 + ((ns - 32'd64) >> 3);
      else                      idx = ns;
      if (idx > 32'(Buckets - 1)) idx = 32'(Buckets - 1);
      slot_of = idx[IdxW-1:0];
    end
  endfunction

  function automatic logic [31:0] slot_floor(input logic [IdxW-1:0] idx);
    logic [31:0] i;
    begin
      i = {22'd0, idx};
      if (i >= 32'd544)      slot_floor = 32'd560384 + ((i - 32'd544) << 15);
      else if (i >= 32'd424) slot_floor = 32'd70144 + ((i - 32'd424) << 12);
      else if (i >= 32'd304) slot_floor = 32'd8704 + ((i - 32'd304) << 9);
      else if (i >= 32'd184) slot_floor = 32'd1024 + ((i - 32'd184) << 6);
      else if (i >= 32'd64)  slot_floor = 32'd64 + ((i - 32'd64) << 3);
      else                   slot_floor = i;
    end
  endfunction
endpackage
`default_nettype wire

/* rtl/lhp_divider.sv */
// restoring divider, one quotient bit a cycle, 64 by 32 bits
`default_nettype none
module lhp_divider
  import lhp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [63:0] quo_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;

  assign trial = {rem_r, quo_r[63]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done   <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
        cnt_r  <= 7'd64;
      end else if (busy_r) begin
        if (!trial[32]) begin
          rem_r <= trial[31:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], quo_r[63]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end
  assign quotient = quo_r;
endmodule
`default_nettype wire

/* rtl/latency_histogram_percentiles_core.sv */
// top level of the latency histogram with percentile queries
//
// in channel: tdata holds latency_ns in bits 31:0, tuser holds action.
// a record item is accepted, then reads and writes back one bucket word
// and gives no result. a clear is accepted and then sweeps the
// 608 bucket words, one a cycle.
// a query runs the mean divider and then scans the buckets, each in
// read, accumulate, multiply and compare steps, with a further multiply
// and compare for each percentile resolved; one item of 256 bits then
// waits on the out channel, fields from the low bits: n_recorded, min,
// max, mean and the four percentiles. an empty query gives its result
// the cycle after.
// after reset a sweep clears all 608 bucket words, during which
// in_tready stays low; config writes are taken at any edge and belong to
// idle periods only.
// in_tready is low while an item is at work or a result waits, so a stall
// of the receiver holds the result and blocks new items.
`default_nettype none
`include "latency_histogram_percentiles_core_macros.svh"
module latency_histogram_percentiles_core
  import lhp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,  // latency_ns
  input  wire logic [1:0]   in_tuser,  // action
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // n_recorded, min_latency, max_latency, mean_latency, first_pct_ns,
  // second_pct_ns, third_pct_ns, fourth_pct_ns
  output logic [255:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [9:0]   cfg_data
);
  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_REC_RD, S_REC_WR, S_DIV, S_SCAN_RD, S_SCAN_ACC,
    S_SCAN_CMP, S_FILL, S_OUT
  } state_t;

  logic [CntW-1:0] mem [Buckets];
  logic [CntW-1:0] rd_r;
  state_t          st_r;
  logic [IdxW-1:0] ptr_r;
  logic [31:0]     ns_r;
  logic [63:0]     total_r;
  logic [CntW-1:0] seen_r;
  logic [31:0]     min_r, max_r, mean_r;
  logic [9:0]      pct_r [4];
  logic [41:0]     acc_r;
  logic [51:0]     lhs_r, rhs_r;
  logic [1:0]      pi_r;
  logic [31:0]     res_r [4];
  logic            div_start, div_done;
  logic [63:0]     div_q;
  logic            mem_we;
  logic [CntW-1:0] mem_wd;
  logic [IdxW-1:0] mem_addr;
  logic            in_acc;

  assign in_tready = (st_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;
  assign out_tvalid = (st_r == S_OUT);
  assign out_tdata = {res_r[3], res_r[2], res_r[1], res_r[0],
                      mean_r, max_r, (seen_r == '0) ? 32'd0 : min_r, seen_r};
  assign div_start = in_acc && (action_t'(in_tuser) == ACT_QUERY) && (seen_r != '0);

  lhp_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(total_r),
    .divisor(seen_r), .done(div_done), .quotient(div_q)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_wd = '0;
    mem_addr = ptr_r;
    if (st_r == S_CLEAR) mem_we = 1'b1;
    if (st_r == S_REC_WR) begin
      mem_we = 1'b1;
      mem_wd = (rd_r == '1) ? rd_r : rd_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLEAR;
      ptr_r   <= '0;
      total_r <= '0;
      seen_r  <= '0;
      min_r   <= '1;
      max_r   <= '0;
      pct_r[0] <= 10'd500;
      pct_r[1] <= 10'd950;
      pct_r[2] <= 10'd990;
      pct_r[3] <= 10'd999;
    end else begin
      if (cfg_we) pct_r[cfg_index - CFG_PCT0] <= cfg_data;
      unique case (st_r)
        S_CLEAR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == IdxW'(Buckets - 1)) begin
            ptr_r <= '0;
            st_r  <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            ns_r <= in_tdata;
            unique case (action_t'(in_tuser))
              ACT_RECORD: begin
                ptr_r <= slot_of(in_tdata);
                st_r  <= S_REC_RD;
              end
              ACT_QUERY: begin
                if (seen_r == '0) begin
                  mean_r <= '0;
                  for (int k = 0; k < 4; k++) res_r[k] <= '0;
                  st_r <= S_OUT;
                end else st_r <= S_DIV;
              end
              ACT_CLEAR: begin
                ptr_r   <= '0;
                total_r <= '0;
                seen_r  <= '0;
                min_r   <= '1;
                max_r   <= '0;
                st_r    <= S_CLEAR;
              end
              default: ;
            endcase
          end
        end
        S_REC_RD: st_r <= S_REC_WR;
        S_REC_WR: begin
          total_r <= total_r + {32'd0, ns_r};
          if (seen_r != '1) seen_r <= seen_r + 1'b1;
          if (ns_r < min_r) min_r <= ns_r;
          if (ns_r > max_r) max_r <= ns_r;
          st_r <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            mean_r <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
            ptr_r  <= '0;
            acc_r  <= '0;
            pi_r   <= '0;
            st_r   <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: st_r <= S_SCAN_ACC;
        S_SCAN_ACC: begin
          acc_r <= acc_r + {10'd0, rd_r};
          st_r  <= S_SCAN_CMP;
          lhs_r <= '0;
        end
        S_SCAN_CMP: begin
          lhs_r <= 52'(acc_r) * 52'd1000;
          rhs_r <= 52'(seen_r) * 52'(pct_r[pi_r]);
          st_r  <= S_FILL;
        end
        S_FILL: begin
          if (lhs_r >= rhs_r) begin
            res_r[pi_r] <= slot_floor(ptr_r);
            pi_r <= pi_r + 1'b1;
            if (pi_r == 2'd3) st_r <= S_OUT;
            else st_r <= S_SCAN_CMP;
          end else if (ptr_r == IdxW'(Buckets - 1)) begin
            for (int k = 0; k < 4; k++)
              if (2'(k) >= pi_r) res_r[k] <= max_r;
            st_r <= S_OUT;
          end else begin
            ptr_r <= ptr_r + 1'b1;
            st_r  <= S_SCAN_RD;
          end
        end
        S_OUT: if (out_tready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `LHP_ASSERT_IMP(a_ready_no_out, clk, rst_n, out_tvalid, !in_tready)
  `LHP_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `LHP_ASSERT_IMP(a_min_le_max, clk, rst_n, in_tready && seen_r != '0, min_r <= max_r)
endmodule
`default_nettype wire

/* tb/sv/latency_histogram_percentiles_core_test.sv */
// self-checking testbench of the latency histogram core: predicted statistics vs query results
`timescale 1ns / 1ps
module latency_histogram_percentiles_core_test;
  import lhp_pkg::*;

  localparam int NumBuckets = Buckets;
  localparam int WatchLimit = 20000;
  localparam int SettleCycles = 800;
  localparam int LongHold = 3000;
  localparam logic [1:0] CFG_PCT1 = 2'd1;
  localparam logic [1:0] CFG_PCT2 = 2'd2;
  localparam logic [1:0] CFG_PCT3 = 2'd3;

  typedef struct {
    action_t     act;
    logic [31:0] ns;
  } sample_item_t;

  typedef struct {
    logic [31:0] f [8];
  } stats_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [255:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [9:0] cfg_data = '0;

  latency_histogram_percentiles_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // histogram mirror
  logic [31:0] hist [NumBuckets];
  logic [63:0] sum_ns;
  logic [31:0] n_samples;
  logic [31:0] min_ns;
  logic [31:0] max_ns;
  logic [9:0] target_pm [4];

  sample_item_t pending_items[$];
  stats_t expected_stats[$];
  int errors = 0;
  int results_seen = 0;
  bit quiet = 1'b0;

  const string field_names [8] = '{"n_recorded", "min_latency", "max_latency", "mean_latency",
    "first_pct_ns", "second_pct_ns", "third_pct_ns", "fourth_pct_ns"};
  const logic [31:0] tier_ns [6] = '{0, 64, 1024, 8704, 70144, 560384};
  const logic [31:0] tier_slot [6] = '{0, 64, 184, 304, 424, 544};
  const int tier_sh [6] = '{0, 3, 6, 9, 12, 15};

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int bucket_of(logic [31:0] ns);
    int t;
    logic [31:0] idx;
    t = 5;
    while (t > 0 && ns < tier_ns[t]) t--;
    idx = tier_slot[t] + ((ns - tier_ns[t]) >> tier_sh[t]);
    if (idx > NumBuckets - 1) idx = NumBuckets - 1;
    return int'(idx);
  endfunction

  function automatic logic [31:0] bucket_floor(int idx);
    int t;
    t = 5;
    while (t > 0 && idx < tier_slot[t]) t--;
    return tier_ns[t] + ((32'(idx) - tier_slot[t]) << tier_sh[t]);
  endfunction

  task automatic wipe_histogram();
    foreach (hist[i]) hist[i] = '0;
    sum_ns = '0;
    n_samples = '0;
    min_ns = '1;
    max_ns = '0;
  endtask

  task automatic apply_item(action_t a, logic [31:0] ns);
    stats_t s;
    int b;
    int p;
    logic [63:0] acc;
    logic [63:0] mean;
    case (a)
      ACT_RECORD: begin
        b = bucket_of(ns);
        if (hist[b] != '1) hist[b]++;
        sum_ns += 64'(ns);
        if (n_samples != '1) n_samples++;
        if (ns < min_ns) min_ns = ns;
        if (ns > max_ns) max_ns = ns;
      end
      ACT_CLEAR: wipe_histogram();
      ACT_QUERY: begin
        foreach (s.f[i]) s.f[i] = '0;
        if (n_samples != 0) begin
          mean = sum_ns / 64'(n_samples);
          s.f[0] = n_samples;
          s.f[1] = min_ns;
          s.f[2] = max_ns;
          s.f[3] = (mean > 64'hFFFF_FFFF) ? '1 : mean[31:0];
          acc = '0;
          p = 0;
          for (int i = 0; i < NumBuckets && p < 4; i++) begin
            acc += 64'(hist[i]);
            while (p < 4 && acc * 1000 >= 64'(n_samples) * 64'(target_pm[p])) begin
              s.f[4 + p] = bucket_floor(i);
              p++;
            end
          end
          for (; p < 4; p++) s.f[4 + p] = max_ns;
        end
        expected_stats.push_back(s);
      end
      default: ;
    endcase
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    sample_item_t it;
    logic nxt_valid;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      nxt_valid = in_tvalid;
      if (in_tvalid && in_tready) begin
        apply_item(action_t'(in_tuser), in_tdata);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 7);
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          in_tuser <= it.act;
          in_tdata <= it.ns;
          nxt_valid = 1'b1;
        end
      end
      in_tvalid <= nxt_valid;
    end
  end

  // result monitor
  int out_gap = 0;
  bit held_long = 1'b0;
  always @(posedge clk) begin
    stats_t s;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_stats.size() == 0) begin
          $error("result with no query outstanding");
          errors++;
        end else begin
          s = expected_stats.pop_front();
          for (int k = 0; k < 8; k++) begin
            if (out_tdata[32*k +: 32] !== s.f[k]) begin
              $error("%s: expected %0d, got %0d", field_names[k], s.f[k], out_tdata[32*k +: 32]);
              errors++;
            end
          end
        end
      end
      if (!held_long && results_seen == 4) begin
        held_long = 1'b1;
        out_gap = LongHold;
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_gap = $urandom_range(1, 7);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  int stuck = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WatchLimit) begin
      $display("latency_histogram_percentiles_core_test failed");
      $finish;
    end
  end

  task automatic add_item(action_t a, logic [31:0] ns);
    sample_item_t it;
    it.act = a;
    it.ns = ns;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_stats.size() > 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_targets(logic [9:0] a, logic [9:0] b, logic [9:0] c, logic [9:0] d);
    logic [9:0] v [4];
    logic [1:0] ix [4];
    v = '{a, b, c, d};
    ix = '{CFG_PCT0, CFG_PCT1, CFG_PCT2, CFG_PCT3};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= ix[i];
      cfg_data <= v[i];
      target_pm[i] = v[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [31:0] rand_latency(int mode);
    case (mode)
      0: return $urandom_range(0, 200);
      1: return tier_ns[$urandom_range(1, 5)] + $urandom_range(0, 3) - 2;
      2: return $urandom_range(0, 3000000);
      3: return 32'd20000000 + $urandom_range(0, 1000);
      default: return $urandom();
    endcase
  endfunction

  task automatic random_phase(int count, int mode_hi);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 84) add_item(ACT_RECORD, rand_latency($urandom_range(0, mode_hi)));
      else if (r < 95) add_item(ACT_QUERY, $urandom());
      else if (r < 98) add_item(ACT_CLEAR, $urandom());
      else add_item(ACT_NONE, $urandom());
    end
    add_item(ACT_QUERY, '0);
  endtask

  initial begin
    wipe_histogram();
    target_pm = '{10'd500, 10'd950, 10'd990, 10'd999};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty query, tier edges, clamp, ignored action, clear
    add_item(ACT_QUERY, '0);
    foreach (tier_ns[t]) begin
      if (t > 0) add_item(ACT_RECORD, tier_ns[t] - 1);
      add_item(ACT_RECORD, tier_ns[t]);
    end
    add_item(ACT_RECORD, '1);
    add_item(ACT_RECORD, 32'd2500000);
    add_item(ACT_QUERY, '1);
    add_item(ACT_NONE, 32'd5);
    add_item(ACT_QUERY, '0);
    add_item(ACT_CLEAR, '0);
    add_item(ACT_QUERY, '0);
    add_item(ACT_RECORD, 32'd7);
    add_item(ACT_QUERY, '0);
    drain();

    set_targets(10'd1, 10'd1, 10'd1, 10'd1);
    random_phase(170, 4);
    drain();
    set_targets(10'd1000, 10'd1000, 10'd1000, 10'd1000);
    random_phase(170, 4);
    drain();
    set_targets(10'd0, 10'd1023, 10'd300, 10'd1000);
    random_phase(170, 1);
    drain();
    set_targets(10'd900, 10'd100, 10'd999, 10'd500);
    random_phase(170, 2);
    drain();
    set_targets(10'($urandom_range(1, 1000)), 10'($urandom_range(1, 1000)),
                10'($urandom_range(1, 1000)), 10'($urandom_range(1, 1000)));
    random_phase(170, 4);
    quiet = 1'b1;
    random_phase(150, 4);
    drain();

    if (errors == 0) begin
      $display("latency_histogram_percentiles_core_test passed");
    end else begin
      $display("latency_histogram_percentiles_core_test failed");
    end
    $finish;
  end
endmodule

/* files.f */
+incdir+rtl
rtl/lhp_pkg.sv
rtl/lhp_divider.sv
rtl/latency_histogram_percentiles_core.sv
tb/sv/latency_histogram_percentiles_core_test.sv
